[hw/rtl/ptas_pkg.sv]
// Package for the priority task and alarm scheduler.
// Shared types, codes and sizing constants. No dependencies.
`timescale 1ns / 1ps
package ptas_pkg;
   localparam int NUM_TASKS_DEF  = 26;
   localparam int MAX_ALARMS_DEF = 8;
   localparam int TID_W  = 5;
   localparam int PRIO_W = 8;
   localparam int PER_W  = 16;
   localparam int FIRE_W = 4;

   typedef enum logic [2:0] {
      OP_CREATE = 3'd0, OP_ALARM = 3'd1, OP_ACTIVATE = 3'd2, OP_CHAIN = 3'd3,
      OP_TERMINATE = 3'd4, OP_TICK = 3'd5, OP_START = 3'd6, OP_NONE = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      MODE_SUSP = 2'd0, MODE_READY = 2'd1, MODE_RUN = 2'd2, MODE_RSVD = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_UNKNOWN = 2'd1, ST_FULL = 2'd2, ST_RSVD = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_PREP, S_SCAN, S_TICK, S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request, do single-cycle part
      logic scan_clr;  // clear scan index and best
      logic scan_step; // examine one task
      logic sched_end; // commit scheduling result
      logic tick_step; // process one alarm
      logic rsp_load;  // latch result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       needs_sched;
      logic       is_tick;
      logic       scan_last;
      logic       tick_last;
   } stat_type;
endpackage

[hw/rtl/priority_task_and_alarm_scheduler.sv]
// Fixed-priority task scheduler with periodic alarms, top level.
// Sequence: accept in IDLE, PREP, then a scan of all tasks (one task per cycle of scan) for
// scheduling ops or a walk of all alarms for tick; create/set alarm/unused go straight to DONE.
// Throughput: one item at a time; a new request is accepted only in IDLE, after DONE has
// registered the result; a stalled result holds DONE.
// Sync active-high reset clears present bits, counters, running task; deps ptas_pkg/ctrl/dp.
`timescale 1ns / 1ps
module priority_task_and_alarm_scheduler #(
   parameter int NUM_TASKS  = ptas_pkg::NUM_TASKS_DEF,
   parameter int MAX_ALARMS = ptas_pkg::MAX_ALARMS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_operation,
   input  logic [ptas_pkg::TID_W-1:0]    req_task_id,
   input  logic [ptas_pkg::PRIO_W-1:0]   req_task_priority,
   input  logic                          req_autostart,
   input  logic [ptas_pkg::PER_W-1:0]    req_alarm_period,
   input  logic                          req_alarm_on,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ptas_pkg::TID_W-1:0]    rsp_running_task,
   output logic                          rsp_running_valid,
   output logic                          rsp_idle,
   output logic [ptas_pkg::FIRE_W-1:0]   rsp_alarms_fired,
   output logic [1:0]                    rsp_status
);
   import ptas_pkg::*;

   cmd_type  cmd;
   stat_type st;

   // controller sequences: accept, prepare, scan or tick walk, deliver
   ptas_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .st, .cmd
   );

   // datapath holds all tables and the result register
   ptas_dp #(.NUM_TASKS(NUM_TASKS), .MAX_ALARMS(MAX_ALARMS)) u_dp (
      .clock, .reset, .cmd, .st,
      .req_operation, .req_task_id, .req_task_priority, .req_autostart,
      .req_alarm_period, .req_alarm_on,
      .rsp_running_task, .rsp_running_valid, .rsp_idle,
      .rsp_alarms_fired, .rsp_status
   );

   // running flag and idle flag are never both set in a result
   a_run_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_running_valid && rsp_idle))
      else $error("running and idle both set");

   // no task reported when nothing runs
   a_task_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_running_valid) |-> rsp_running_task == '0)
      else $error("running task nonzero while invalid");

   // a stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_running_task) &&
      $stable(rsp_running_valid) && $stable(rsp_idle) &&
      $stable(rsp_alarms_fired) && $stable(rsp_status)))
      else $error("stalled result changed");

   // reserved status code never reported
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'(ST_RSVD))
      else $error("reserved status code");
endmodule

[hw/rtl/ptas_ctrl.sv]
// Controller state machine for the scheduler.
// Depends on ptas_pkg.
`timescale 1ns / 1ps
module ptas_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  ptas_pkg::stat_type st,
   output ptas_pkg::cmd_type  cmd
);
   import ptas_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_PREP;
         S_PREP: begin
            if (st.needs_sched) state_in = S_SCAN;
            else if (st.is_tick) state_in = S_TICK;
            else state_in = S_DONE;
         end
         S_SCAN: if (st.scan_last) state_in = S_DONE;
         S_TICK: if (st.tick_last) state_in = S_DONE;
         S_DONE: if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         S_PREP: begin
            cmd.scan_clr = 1'b1;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.sched_end = st.scan_last;
         end
         S_TICK: cmd.tick_step = 1'b1;
         S_DONE: cmd.rsp_load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

[hw/rtl/ptas_dp.sv]
// Datapath for the scheduler: task table, alarm list, scan unit, result register.
// Depends on ptas_pkg.
`timescale 1ns / 1ps
module ptas_dp #(
   parameter int NUM_TASKS  = ptas_pkg::NUM_TASKS_DEF,
   parameter int MAX_ALARMS = ptas_pkg::MAX_ALARMS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ptas_pkg::cmd_type             cmd,
   output ptas_pkg::stat_type            st,
   input  logic [2:0]                    req_operation,
   input  logic [ptas_pkg::TID_W-1:0]    req_task_id,
   input  logic [ptas_pkg::PRIO_W-1:0]   req_task_priority,
   input  logic                          req_autostart,
   input  logic [ptas_pkg::PER_W-1:0]    req_alarm_period,
   input  logic                          req_alarm_on,
   output logic [ptas_pkg::TID_W-1:0]    rsp_running_task,
   output logic                          rsp_running_valid,
   output logic                          rsp_idle,
   output logic [ptas_pkg::FIRE_W-1:0]   rsp_alarms_fired,
   output logic [1:0]                    rsp_status
);
   import ptas_pkg::*;

   localparam int TI_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int AI_W = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
   localparam int AC_W = $clog2(MAX_ALARMS + 1);

   logic [NUM_TASKS-1:0]   present_ff;
   logic [PRIO_W-1:0]      prio_ff  [NUM_TASKS];
   mode_type               mode_ff  [NUM_TASKS];
   logic [TID_W-1:0]       order_ff [NUM_TASKS];
   logic [TID_W-1:0]       created_ff;
   logic [TID_W-1:0]       a_tgt_ff [MAX_ALARMS];
   logic [PER_W-1:0]       a_rel_ff [MAX_ALARMS];
   logic [PER_W-1:0]       a_rem_ff [MAX_ALARMS];
   logic [MAX_ALARMS-1:0]  a_en_ff;
   logic [AC_W-1:0]        acount_ff;
   logic [TID_W-1:0]       cur_ff;
   logic                   curv_ff, idle_ff;

   op_type                 op_ff;
   logic [TID_W-1:0]       id_ff;
   status_type             status_ff;
   logic [FIRE_W-1:0]      fired_ff;
   logic [TI_W-1:0]        sidx_ff;
   logic [AI_W-1:0]        aidx_ff;
   logic                   bestv_ff;
   logic [TI_W-1:0]        best_ff;
   logic [PRIO_W-1:0]      bprio_ff;
   logic [TID_W-1:0]       border_ff;

   op_type                 req_op;
   logic                   req_in_range, req_known;
   logic [TI_W-1:0]        req_ti;

   assign req_op       = op_type'(req_operation);
   assign req_in_range = ({1'b0, req_task_id} < (TID_W+1)'(NUM_TASKS));
   assign req_ti       = req_task_id[TI_W-1:0];
   assign req_known    = req_in_range && present_ff[req_ti];

   // scan candidate
   logic cand_ok, cand_better;
   assign cand_ok = present_ff[sidx_ff] && mode_ff[sidx_ff] == MODE_READY
                    && prio_ff[sidx_ff] != '0;
   assign cand_better = !bestv_ff || prio_ff[sidx_ff] > bprio_ff ||
                        (prio_ff[sidx_ff] == bprio_ff && order_ff[sidx_ff] < border_ff);

   // alarm step
   logic [AI_W-1:0]  ak;
   logic [PER_W-1:0] a_dec;
   logic             a_act, a_fire, a_tknown;
   logic [TI_W-1:0]  a_ti;
   assign ak     = aidx_ff;
   assign a_dec  = a_rem_ff[ak] - PER_W'(1);
   assign a_act  = ({1'b0, ak} < acount_ff) && a_en_ff[ak];
   assign a_fire = a_act && a_dec == '0;
   assign a_ti   = a_tgt_ff[ak][TI_W-1:0];
   assign a_tknown = ({1'b0, a_tgt_ff[ak]} < (TID_W+1)'(NUM_TASKS)) && present_ff[a_ti];

   logic cur_ok;
   logic [TI_W-1:0] cur_ti;
   assign cur_ti = cur_ff[TI_W-1:0];
   assign cur_ok = curv_ff && ({1'b0, cur_ff} < (TID_W+1)'(NUM_TASKS));

   assign st.needs_sched = op_ff == OP_ACTIVATE || op_ff == OP_CHAIN ||
                           op_ff == OP_TERMINATE || op_ff == OP_START;
   assign st.is_tick     = op_ff == OP_TICK;
   assign st.scan_last   = {1'b0, sidx_ff} == (TI_W+1)'(NUM_TASKS - 1);
   assign st.tick_last   = {1'b0, aidx_ff} == (AI_W+1)'(MAX_ALARMS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         created_ff <= '0;
         acount_ff  <= '0;
         cur_ff     <= '0;
         curv_ff    <= 1'b0;
         idle_ff    <= 1'b0;
         op_ff      <= OP_NONE;
      end else begin
         if (cmd.load) begin
            op_ff     <= req_op;
            id_ff     <= req_task_id;
            status_ff <= ST_OK;
            fired_ff  <= '0;
            case (req_op)
               OP_CREATE: begin
                  if (!req_in_range) status_ff <= ST_UNKNOWN;
                  else begin
                     if (!present_ff[req_ti]) begin
                        present_ff[req_ti] <= 1'b1;
                        order_ff[req_ti]   <= created_ff;
                        created_ff         <= created_ff + TID_W'(1);
                     end else if (curv_ff && cur_ff == req_task_id) begin
                        curv_ff <= 1'b0;
                     end
                     prio_ff[req_ti] <= req_task_priority;
                     mode_ff[req_ti] <= req_autostart ? MODE_READY : MODE_SUSP;
                  end
               end
               OP_ALARM: begin
                  if (!req_known) status_ff <= ST_UNKNOWN;
                  else if (acount_ff >= AC_W'(MAX_ALARMS)) status_ff <= ST_FULL;
                  else begin
                     a_tgt_ff[acount_ff[AI_W-1:0]] <= req_task_id;
                     a_rel_ff[acount_ff[AI_W-1:0]] <= req_alarm_period;
                     a_rem_ff[acount_ff[AI_W-1:0]] <= req_alarm_period;
                     a_en_ff[acount_ff[AI_W-1:0]]  <= req_alarm_on;
                     acount_ff <= acount_ff + AC_W'(1);
                  end
               end
               OP_ACTIVATE, OP_CHAIN, OP_TERMINATE, OP_START: begin
                  if (cur_ok) begin
                     mode_ff[cur_ti] <= (req_op == OP_ACTIVATE || req_op == OP_START)
                                        ? MODE_READY : MODE_SUSP;
                  end
               end
               default: ;
            endcase
         end
         // PREP: ready the target after the current task's mode change
         if (cmd.scan_clr) begin
            sidx_ff  <= '0;
            aidx_ff  <= '0;
            bestv_ff <= 1'b0;
            if (op_ff == OP_ACTIVATE || op_ff == OP_CHAIN) begin
               if (({1'b0, id_ff} < (TID_W+1)'(NUM_TASKS)) && present_ff[id_ff[TI_W-1:0]])
                  mode_ff[id_ff[TI_W-1:0]] <= MODE_READY;
               else status_ff <= ST_UNKNOWN;
            end
         end
         if (cmd.scan_step) begin
            sidx_ff <= sidx_ff + TI_W'(1);
            if (cand_ok && cand_better) begin
               bestv_ff  <= 1'b1;
               best_ff   <= sidx_ff;
               bprio_ff  <= prio_ff[sidx_ff];
               border_ff <= order_ff[sidx_ff];
            end
         end
         if (cmd.sched_end) begin
            if (cand_ok && cand_better) begin
               mode_ff[sidx_ff] <= MODE_RUN;
               cur_ff  <= TID_W'(sidx_ff);
               curv_ff <= 1'b1;
               idle_ff <= 1'b0;
            end else if (bestv_ff) begin
               mode_ff[best_ff] <= MODE_RUN;
               cur_ff  <= TID_W'(best_ff);
               curv_ff <= 1'b1;
               idle_ff <= 1'b0;
            end else begin
               curv_ff <= 1'b0;
               idle_ff <= 1'b1;
            end
         end
         if (cmd.tick_step) begin
            aidx_ff <= aidx_ff + AI_W'(1);
            if (a_act) begin
               a_rem_ff[ak] <= a_fire ? a_rel_ff[ak] : a_dec;
               if (a_fire) begin
                  if (fired_ff != '1) fired_ff <= fired_ff + FIRE_W'(1);
                  if (a_tknown && mode_ff[a_ti] != MODE_RUN) mode_ff[a_ti] <= MODE_READY;
               end
            end
         end
         if (cmd.rsp_load) begin
            rsp_running_task  <= curv_ff ? cur_ff : '0;
            rsp_running_valid <= curv_ff;
            rsp_idle          <= idle_ff;
            rsp_alarms_fired  <= fired_ff;
            rsp_status        <= status_ff;
         end
      end
   end
endmodule
